// File: rtl/core/lcer_pkg.sv
// lcer_pkg: shared types and constants of the LED current exposure regulator
// request and result payloads, configuration register set, regulator state and register indexes
// no dependencies
package lcer_pkg;

    localparam int EXPOSURE_W = 10;
    localparam int LEVEL_W    = 5;
    localparam int STEP_W     = 3;
    localparam int HOLD_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [7:0] LED_ON_BASE  = 8'hE0;
    localparam logic [7:0] LED_OFF_CODE = 8'hFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EXPOSURE_HIGH_BOUND    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPOSURE_LOW_BOUND     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXPOSURE_HIGH_CONTINUE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXPOSURE_LOW_CONTINUE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_MAX            = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_MIN            = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_STEP           = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_LIMIT             = 3'd7;

    typedef logic [EXPOSURE_W-1:0] t_exposure;
    typedef logic [LEVEL_W-1:0]    t_level;

    typedef enum logic [1:0] {
        PH_NORMAL = 2'd0,
        PH_UP     = 2'd1,
        PH_DOWN   = 2'd2
    } t_phase;

    typedef struct packed {
        logic      sensing_active;
        t_exposure exposure;
    } t_in;

    typedef struct packed {
        logic       drive_write;
        logic [7:0] led_drive_code;
        t_level     drive_level;
        logic       current_changed;
    } t_out;

    typedef struct packed {
        t_exposure           exposure_high_bound;
        t_exposure           exposure_low_bound;
        t_exposure           exposure_high_continue;
        t_exposure           exposure_low_continue;
        t_level              current_max;
        t_level              current_min;
        logic [STEP_W-1:0]   current_step;
        logic [HOLD_W-1:0]   hold_limit;
    } t_cfg;

    typedef struct packed {
        t_level            level;
        t_phase            ramp_phase;
        logic [HOLD_W-1:0] hold_counter;
        logic              asleep;
    } t_state;

endpackage

// File: rtl/core/lcer_step.sv
// lcer_step: one regulator step, next state and result from current state and request
// combinational; depends on lcer_pkg
module lcer_step
    import lcer_pkg::*;
#(
    parameter int DEFAULT_LEVEL = 5
) (
    input  t_cfg   i_cfg,
    input  t_state i_state,
    input  t_in    i_req,
    output t_state o_state,
    output t_out   o_result
);

    localparam t_level DEF_LEVEL = LEVEL_W'(DEFAULT_LEVEL);

    logic [LEVEL_W:0]   sum_up;
    logic [LEVEL_W:0]   min_plus;
    logic               dn_clamp;
    t_level             lvl_dn;
    logic               wake;
    logic               changed;
    t_state             n_state;

    always_comb begin
        sum_up   = {1'b0, i_state.level} + {{(LEVEL_W-STEP_W+1){1'b0}}, i_cfg.current_step};
        min_plus = {1'b0, i_cfg.current_min} + {{(LEVEL_W-STEP_W+1){1'b0}}, i_cfg.current_step};
        dn_clamp = {1'b0, i_state.level} <= min_plus;
        lvl_dn   = i_state.level - {{(LEVEL_W-STEP_W){1'b0}}, i_cfg.current_step};
    end

    always_comb begin
        n_state = i_state;
        wake    = 1'b0;
        changed = 1'b0;
        if (i_req.sensing_active) begin
            wake           = i_state.asleep;
            n_state.asleep = 1'b0;
            if (i_state.hold_counter <= i_cfg.hold_limit) begin
                n_state.hold_counter = i_state.hold_counter + 3'd1;
            end else begin
                n_state.hold_counter = '0;
                case (i_state.ramp_phase)
                    PH_NORMAL: begin
                        if (i_req.exposure >= i_cfg.exposure_high_bound &&
                            i_state.level < i_cfg.current_max) begin
                            n_state.ramp_phase = PH_UP;
                            n_state.level = (sum_up > {1'b0, i_cfg.current_max}) ?
                                            i_cfg.current_max : sum_up[LEVEL_W-1:0];
                            changed = 1'b1;
                        end else if (i_req.exposure <= i_cfg.exposure_low_bound &&
                                     i_state.level > i_cfg.current_min) begin
                            n_state.ramp_phase = PH_DOWN;
                            n_state.level = dn_clamp ? i_cfg.current_min : lvl_dn;
                            changed = 1'b1;
                        end
                    end
                    PH_UP: begin
                        if (i_req.exposure > i_cfg.exposure_high_continue) begin
                            if (sum_up >= {1'b0, i_cfg.current_max}) begin
                                n_state.ramp_phase = PH_NORMAL;
                                n_state.level      = i_cfg.current_max;
                            end else begin
                                n_state.level = sum_up[LEVEL_W-1:0];
                            end
                            changed = 1'b1;
                        end else begin
                            n_state.ramp_phase = PH_NORMAL;
                        end
                    end
                    default: begin
                        // downward ramp; the unused phase code behaves the same
                        if (i_req.exposure < i_cfg.exposure_low_continue) begin
                            if (dn_clamp) begin
                                n_state.ramp_phase = PH_NORMAL;
                                n_state.level      = i_cfg.current_min;
                            end else begin
                                n_state.ramp_phase = PH_DOWN;
                                n_state.level      = lvl_dn;
                            end
                            changed = 1'b1;
                        end else begin
                            n_state.ramp_phase = PH_NORMAL;
                        end
                    end
                endcase
            end
        end else begin
            // going to sleep: ramp phase and hold counter keep their values
            n_state.level  = DEF_LEVEL;
            n_state.asleep = 1'b1;
        end
    end

    always_comb begin
        o_state                  = n_state;
        o_result.drive_level     = n_state.level;
        o_result.current_changed = changed;
        o_result.drive_write     = changed || wake || !i_req.sensing_active;
        if (changed) begin
            o_result.led_drive_code = LED_ON_BASE | {3'b000, n_state.level};
        end else if (wake) begin
            o_result.led_drive_code = LED_ON_BASE | {3'b000, DEF_LEVEL};
        end else if (!i_req.sensing_active) begin
            o_result.led_drive_code = LED_OFF_CODE;
        end else begin
            o_result.led_drive_code = LED_ON_BASE | {3'b000, n_state.level};
        end
    end

endmodule

// File: rtl/core/led_current_exposure_regulator.sv
// led_current_exposure_regulator: a request accepted into the input register moves on into the
// result register, where its result is offered to the consumer; throughput one request per
// cycle unless a held result stalls the pipeline, since the regulator state is updated in the
// same cycle the request moves into the result register
// reset (synchronous, active low) clears both stages and loads the register defaults,
// level DEFAULT_LEVEL, normal phase, hold counter 0, asleep; depends on lcer_pkg and lcer_step
module led_current_exposure_regulator
    import lcer_pkg::*;
#(
    parameter int EXPOSURE_BITS = 10,
    parameter int DEFAULT_LEVEL = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int        EXP_KEEP = (EXPOSURE_BITS < EXPOSURE_W) ? EXPOSURE_BITS : EXPOSURE_W;
    localparam t_exposure EXP_MASK = t_exposure'((64'd1 << EXP_KEEP) - 64'd1);

    t_cfg   r_cfg;
    t_state r_state;
    t_state n_state;
    logic   r_in_valid;
    t_in    r_in_data;
    t_in    masked_req;
    logic   r_out_valid;
    t_out   r_out_data;
    t_out   n_out_data;
    logic   advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.exposure_high_bound    <= 10'd496;
            r_cfg.exposure_low_bound     <= 10'd32;
            r_cfg.exposure_high_continue <= 10'd420;
            r_cfg.exposure_low_continue  <= 10'd64;
            r_cfg.current_max            <= 5'd31;
            r_cfg.current_min            <= 5'd1;
            r_cfg.current_step           <= 3'd2;
            r_cfg.hold_limit             <= 3'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_EXPOSURE_HIGH_BOUND:    r_cfg.exposure_high_bound    <= i_cfg_wdata;
                REG_EXPOSURE_LOW_BOUND:     r_cfg.exposure_low_bound     <= i_cfg_wdata;
                REG_EXPOSURE_HIGH_CONTINUE: r_cfg.exposure_high_continue <= i_cfg_wdata;
                REG_EXPOSURE_LOW_CONTINUE:  r_cfg.exposure_low_continue  <= i_cfg_wdata;
                REG_CURRENT_MAX:            r_cfg.current_max  <= i_cfg_wdata[LEVEL_W-1:0];
                REG_CURRENT_MIN:            r_cfg.current_min  <= i_cfg_wdata[LEVEL_W-1:0];
                REG_CURRENT_STEP:           r_cfg.current_step <= i_cfg_wdata[STEP_W-1:0];
                REG_HOLD_LIMIT:             r_cfg.hold_limit   <= i_cfg_wdata[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    always_comb begin
        masked_req          = r_in_data;
        masked_req.exposure = r_in_data.exposure & EXP_MASK;
    end

    lcer_step #(
        .DEFAULT_LEVEL (DEFAULT_LEVEL)
    ) u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_req    (masked_req),
        .o_state  (n_state),
        .o_result (n_out_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.level        <= LEVEL_W'(DEFAULT_LEVEL);
            r_state.ramp_phase   <= PH_NORMAL;
            r_state.hold_counter <= '0;
            r_state.asleep       <= 1'b1;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: rtl/core/lcer_checker.sv
// lcer_checker: port-level checks of the regulator, bound to the top level
// depends on lcer_pkg and led_current_exposure_regulator
module lcer_checker
    import lcer_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    // a result waiting for the consumer holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // without a write the code mirrors the current level
    a_idle_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.drive_write |->
            o_out_data.led_drive_code[7:5] == 3'b111 &&
            o_out_data.led_drive_code[4:0] == o_out_data.drive_level)
        else $error("idle code does not match level");

    // an adjustment always writes the new level
    a_change_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.current_changed |->
            o_out_data.drive_write &&
            o_out_data.led_drive_code[7:5] == 3'b111 &&
            o_out_data.led_drive_code[4:0] == o_out_data.drive_level)
        else $error("adjustment without matching write");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind led_current_exposure_regulator lcer_checker u_lcer_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// File: dv/testbench.sv
// testbench: self-checking bench for led_current_exposure_regulator
// drives exposure requests with random gaps and result stalls, predicts every result in place
// depends on lcer_pkg and the regulator rtl
module testbench;
    import lcer_pkg::*;

    localparam t_level WAKE_LEVEL     = 5'd5;
    localparam int     SETTING_COUNT  = 9;
    localparam int     REQS_PER_SET   = 60;

    typedef struct {
        logic      act;
        t_exposure expo;
        bit        typed;
        t_out      want;
    } sample_row_t;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in                   i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out                  o_out_data;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // mirror of the regulator registers and state
    t_cfg              cfg_m    = '{10'd496, 10'd32, 10'd420, 10'd64, 5'd31, 5'd1, 3'd2, 3'd3};
    t_level            level_m  = WAKE_LEVEL;
    t_phase            phase_m  = PH_NORMAL;
    logic [HOLD_W-1:0] hold_m   = '0;
    logic              asleep_m = 1'b1;

    t_out        drive_q[$];
    int unsigned n_err    = 0;
    int unsigned n_req    = 0;
    int unsigned n_adjust = 0;
    int unsigned n_sleep  = 0;
    int unsigned n_seen   = 0;
    bit          no_stall = 1'b0;
    int unsigned trend    = 0;

    // opening sequence from reset defaults: hold limit 3, step 2, level 5
    sample_row_t opening_rows [23] = '{
        '{1'b1, 10'd1023, 1'b1, '{1'b1, LED_ON_BASE | 8'd5, 5'd5, 1'b0}}, // wake from reset
        '{1'b1, 10'd0,    1'b1, '{1'b0, LED_ON_BASE | 8'd5, 5'd5, 1'b0}},
        '{1'b1, 10'd512,  1'b1, '{1'b0, LED_ON_BASE | 8'd5, 5'd5, 1'b0}},
        '{1'b1, 10'd1023, 1'b1, '{1'b0, LED_ON_BASE | 8'd5, 5'd5, 1'b0}},
        '{1'b0, 10'd0,    1'b1, '{1'b1, LED_OFF_CODE, 5'd5, 1'b0}},       // hold count survives
        '{1'b1, 10'd1023, 1'b1, '{1'b1, LED_ON_BASE | 8'd7, 5'd7, 1'b1}}, // wake and step up
        '{1'b1, 10'd1023, 1'b1, '{1'b0, LED_ON_BASE | 8'd7, 5'd7, 1'b0}},
        '{1'b1, 10'd1023, 1'b1, '{1'b0, LED_ON_BASE | 8'd7, 5'd7, 1'b0}},
        '{1'b1, 10'd1023, 1'b1, '{1'b0, LED_ON_BASE | 8'd7, 5'd7, 1'b0}},
        '{1'b1, 10'd1023, 1'b1, '{1'b0, LED_ON_BASE | 8'd7, 5'd7, 1'b0}},
        '{1'b1, 10'd1023, 1'b1, '{1'b1, LED_ON_BASE | 8'd9, 5'd9, 1'b1}}, // ramp goes on
        '{1'b1, 10'd300,  1'b0, '0},
        '{1'b1, 10'd300,  1'b0, '0},
        '{1'b1, 10'd300,  1'b0, '0},
        '{1'b1, 10'd300,  1'b0, '0},
        '{1'b1, 10'd420,  1'b1, '{1'b0, LED_ON_BASE | 8'd9, 5'd9, 1'b0}}, // on continue bound
        '{1'b1, 10'd0,    1'b1, '{1'b0, LED_ON_BASE | 8'd9, 5'd9, 1'b0}},
        '{1'b1, 10'd0,    1'b1, '{1'b0, LED_ON_BASE | 8'd9, 5'd9, 1'b0}},
        '{1'b1, 10'd0,    1'b1, '{1'b0, LED_ON_BASE | 8'd9, 5'd9, 1'b0}},
        '{1'b1, 10'd0,    1'b1, '{1'b0, LED_ON_BASE | 8'd9, 5'd9, 1'b0}},
        '{1'b1, 10'd32,   1'b1, '{1'b1, LED_ON_BASE | 8'd7, 5'd7, 1'b1}}, // on low bound
        '{1'b0, 10'd1023, 1'b1, '{1'b1, LED_OFF_CODE, 5'd5, 1'b0}},
        '{1'b1, 10'd63,   1'b1, '{1'b1, LED_ON_BASE | 8'd5, 5'd5, 1'b0}}
    };

    led_current_exposure_regulator #(
        .DEFAULT_LEVEL(WAKE_LEVEL)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // advances the mirrored state by one request and returns the drive result
    function automatic t_out regulate(input t_in req);
        t_out        r;
        int unsigned nxt;
        int unsigned floor;
        logic        wrote;
        logic        chg;
        logic [7:0]  code;
        wrote = 1'b0;
        chg   = 1'b0;
        code  = '0;
        floor = int'(cfg_m.current_min) + int'(cfg_m.current_step);
        if (req.sensing_active) begin
            if (asleep_m) begin
                code     = LED_ON_BASE | {3'b000, WAKE_LEVEL};
                wrote    = 1'b1;
                asleep_m = 1'b0;
            end
            if (hold_m <= cfg_m.hold_limit) begin
                hold_m = hold_m + 3'd1;
            end else begin
                hold_m = '0;
                case (phase_m)
                    PH_NORMAL: begin
                        if (req.exposure >= cfg_m.exposure_high_bound &&
                            level_m < cfg_m.current_max) begin
                            phase_m = PH_UP;
                            nxt     = int'(level_m) + int'(cfg_m.current_step);
                            level_m = (nxt > cfg_m.current_max) ? cfg_m.current_max
                                                                : t_level'(nxt);
                            chg     = 1'b1;
                        end else if (req.exposure <= cfg_m.exposure_low_bound &&
                                     level_m > cfg_m.current_min) begin
                            phase_m = PH_DOWN;
                            level_m = (level_m <= floor) ? cfg_m.current_min
                                                         : level_m - cfg_m.current_step;
                            chg     = 1'b1;
                        end
                    end
                    PH_UP: begin
                        if (req.exposure > cfg_m.exposure_high_continue) begin
                            nxt = int'(level_m) + int'(cfg_m.current_step);
                            if (nxt >= cfg_m.current_max) begin
                                phase_m = PH_NORMAL;
                                level_m = cfg_m.current_max;
                            end else begin
                                level_m = t_level'(nxt);
                            end
                            chg = 1'b1;
                        end else begin
                            phase_m = PH_NORMAL;
                        end
                    end
                    default: begin
                        if (req.exposure < cfg_m.exposure_low_continue) begin
                            if (level_m <= floor) begin
                                phase_m = PH_NORMAL;
                                level_m = cfg_m.current_min;
                            end else begin
                                phase_m = PH_DOWN;
                                level_m = level_m - cfg_m.current_step;
                            end
                            chg = 1'b1;
                        end else begin
                            phase_m = PH_NORMAL;
                        end
                    end
                endcase
                if (chg) begin
                    code  = LED_ON_BASE | {3'b000, level_m};
                    wrote = 1'b1;
                end
            end
        end else begin
            level_m  = WAKE_LEVEL;
            asleep_m = 1'b1;
            code     = LED_OFF_CODE;
            wrote    = 1'b1;
        end
        if (!wrote) code = LED_ON_BASE | {3'b000, level_m};
        r.drive_write     = wrote;
        r.led_drive_code  = code;
        r.drive_level     = level_m;
        r.current_changed = chg;
        return r;
    endfunction

    // register setting for one phase of the random part
    function automatic t_cfg pick_cfg(input int ph);
        t_cfg s;
        case (ph)
            0: s = '{10'd496, 10'd32, 10'd420, 10'd64, 5'd31, 5'd1, 3'd7, 3'd0};
            1: s = '{10'd1023, 10'd0, 10'd1023, 10'd0, 5'd31, 5'd1, 3'd1, 3'd0};
            2: s = '{10'd0, 10'd1023, 10'd0, 10'd1023, 5'd1, 5'd31, 3'd7, 3'd1}; // min above max
            4: s = '{10'd600, 10'd100, 10'd500, 10'd200, 5'd20, 5'd3, 3'd3, 3'd0};
            default: begin
                s.exposure_high_bound    = t_exposure'($urandom_range(1023, 0));
                s.exposure_low_bound     = t_exposure'($urandom_range(1023, 0));
                s.exposure_high_continue = t_exposure'($urandom_range(1023, 0));
                s.exposure_low_continue  = t_exposure'($urandom_range(1023, 0));
                s.current_max            = t_level'($urandom_range(31, 1));
                s.current_min            = t_level'($urandom_range(31, 1));
                s.current_step           = 3'($urandom_range(7, 1));
                s.hold_limit             = 3'($urandom_range(7, 0));
            end
        endcase
        // hold counter wraps before it can pass the limit, no decision ever taken
        if (ph == 3) s.hold_limit = 3'd7;
        return s;
    endfunction

    // exposure follows a slowly changing trend so ramps get room to run
    function automatic t_in make_req();
        t_in         r;
        int          v;
        int unsigned pick;
        if ($urandom_range(99, 0) < 4) trend = $urandom_range(3, 0);
        r.sensing_active = ($urandom_range(99, 0) >= 6);
        case (trend)
            0: r.exposure = t_exposure'($urandom_range(1023, cfg_m.exposure_high_continue));
            1: r.exposure = t_exposure'($urandom_range(cfg_m.exposure_low_continue, 0));
            2: begin
                pick = $urandom_range(3, 0);
                v = (pick == 0) ? int'(cfg_m.exposure_high_bound) :
                    (pick == 1) ? int'(cfg_m.exposure_low_bound) :
                    (pick == 2) ? int'(cfg_m.exposure_high_continue) :
                                  int'(cfg_m.exposure_low_continue);
                v = v + int'($urandom_range(2, 0)) - 1;
                if (v < 0) v = 0;
                if (v > 1023) v = 1023;
                r.exposure = t_exposure'(v);
            end
            default: r.exposure = t_exposure'($urandom_range(1023, 0));
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch on result %0d: %s", n_seen, msg);
        n_err++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= CFG_DATA_W'(val);
        @(posedge i_clk);
        case (idx)
            REG_EXPOSURE_HIGH_BOUND:    cfg_m.exposure_high_bound    = t_exposure'(val);
            REG_EXPOSURE_LOW_BOUND:     cfg_m.exposure_low_bound     = t_exposure'(val);
            REG_EXPOSURE_HIGH_CONTINUE: cfg_m.exposure_high_continue = t_exposure'(val);
            REG_EXPOSURE_LOW_CONTINUE:  cfg_m.exposure_low_continue  = t_exposure'(val);
            REG_CURRENT_MAX:            cfg_m.current_max            = t_level'(val);
            REG_CURRENT_MIN:            cfg_m.current_min            = t_level'(val);
            REG_CURRENT_STEP:           cfg_m.current_step           = 3'(val);
            REG_HOLD_LIMIT:             cfg_m.hold_limit             = 3'(val);
            default: ;
        endcase
    endtask

    task automatic load_settings(input t_cfg s);
        write_reg(REG_EXPOSURE_HIGH_BOUND,    s.exposure_high_bound);
        write_reg(REG_EXPOSURE_LOW_BOUND,     s.exposure_low_bound);
        write_reg(REG_EXPOSURE_HIGH_CONTINUE, s.exposure_high_continue);
        write_reg(REG_EXPOSURE_LOW_CONTINUE,  s.exposure_low_continue);
        write_reg(REG_CURRENT_MAX,            s.current_max);
        write_reg(REG_CURRENT_MIN,            s.current_min);
        write_reg(REG_CURRENT_STEP,           s.current_step);
        write_reg(REG_HOLD_LIMIT,             s.hold_limit);
        i_cfg_we <= 1'b0;
    endtask

    // valid stays up across back-to-back requests, dropped only for an idle gap
    task automatic send_req(input t_in req, input bit typed, input t_out want);
        t_out got;
        if (!no_stall && $urandom_range(99, 0) < 12) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        got = regulate(req);
        drive_q.push_back(typed ? want : got);
        n_req++;
        if (got.current_changed) n_adjust++;
        if (!req.sensing_active) n_sleep++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (drive_q.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= no_stall || ($urandom_range(99, 0) >= 12);
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_seen++;
            if (drive_q.size() == 0) begin
                report_mismatch("result with nothing outstanding");
            end else begin
                want = drive_q.pop_front();
                check_field("drive_write", o_out_data.drive_write, want.drive_write);
                check_field("led_drive_code", o_out_data.led_drive_code, want.led_drive_code);
                check_field("drive_level", o_out_data.drive_level, want.drive_level);
                check_field("current_changed", o_out_data.current_changed,
                            want.current_changed);
            end
        end
    end

    initial begin
        t_in req;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_rows[k]) begin
            req.sensing_active = opening_rows[k].act;
            req.exposure       = opening_rows[k].expo;
            send_req(req, opening_rows[k].typed, opening_rows[k].want);
        end
        drain_results();

        for (int ph = 0; ph < SETTING_COUNT; ph++) begin
            load_settings(pick_cfg(ph));
            no_stall = (ph == 4);
            for (int n = 0; n < REQS_PER_SET; n++) begin
                send_req(make_req(), 1'b0, '0);
            end
            drain_results();
        end
        no_stall = 1'b0;

        repeat (8) @(posedge i_clk);
        $display("sent %0d requests across %0d register settings", n_req, SETTING_COUNT + 1);
        $display("%0d level adjustments and %0d sleep requests checked", n_adjust, n_sleep);
        if (n_err == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
